FILE: rtl/dqpi_pkg.sv
// ----------------------------------------------------------------------------
// dqpi_pkg
// shared widths, register indexes and saturation helper for the dq current loop
// ----------------------------------------------------------------------------
`default_nettype none

package dqpi_pkg;

  localparam int unsigned DataW  = 32;   // signal width, signed Q16.16
  localparam int unsigned GainW  = 32;   // gain width, unsigned Q8.24
  localparam int unsigned LimW   = 31;   // current limit width
  localparam int unsigned MulW   = 33;   // multiplier operand width
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned WideW  = 48;   // widest value fed to saturation
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FILTER_IND = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CURR_LIMIT = 2'd3;

  localparam logic signed [WideW-1:0] WIDE_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [WideW-1:0] WIDE_MIN = 48'shFFFF_8000_0000;

  // saturate to signed 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > WIDE_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < WIDE_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dq_current_pi_loop.sv
// ----------------------------------------------------------------------------
// dq_current_pi_loop
// dq-frame current pi controller with cross-coupling decoupling feedforward
// ----------------------------------------------------------------------------
// each request takes seven products, one per sequencer step, that all go
// through the single 33x33 multiplier; a new request is taken only when the
// sequencer is back in idle
// the result register frees the input side: a new request is taken while
// the previous result still waits; the last step holds until it is taken
// reset: async active low, clears state, config registers, integrators and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module dq_current_pi_loop
  import dqpi_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [GainW-1:0]     cfg_data_i,
  // input request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: ref_d, ref_q, meas_d, meas_q, cap_volt_d, cap_volt_q, angular_freq
  input  wire logic [7*DataW-1:0]   s_axis_tdata,
  // tuser: enable
  input  wire logic [0:0]           s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: drive_d, drive_q
  output logic [2*DataW-1:0]        m_axis_tdata
);

  // sequencer step codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;  // errors, issue omega*L
  localparam logic [3:0] ST_REACT = 4'd2;  // reactance, issue err_d*ki
  localparam logic [3:0] ST_INTD  = 4'd3;  // integ_d, issue x*meas_q
  localparam logic [3:0] ST_CRSD  = 4'd4;  // feedforward d, issue x*meas_d
  localparam logic [3:0] ST_CRSQ  = 4'd5;  // feedforward q, issue err_q*ki
  localparam logic [3:0] ST_INTQ  = 4'd6;  // integ_q, issue err_d*kp
  localparam logic [3:0] ST_SUMD  = 4'd7;  // pi sum d, issue err_q*kp
  localparam logic [3:0] ST_SUMQ  = 4'd8;  // pi sum q, final d
  localparam logic [3:0] ST_DONE  = 4'd9;  // final q, hand to output

  localparam int unsigned SumW = 42;

  logic [3:0] state_q, state_d;

  // config registers
  logic [GainW-1:0] kp_q, ki_q, ind_q;
  logic [LimW-1:0]  lim_q;

  // latched request
  logic                    en_q;
  logic signed [DataW-1:0] ref_d_q, ref_q_q, meas_d_q, meas_q_q;
  logic signed [DataW-1:0] cap_d_q, cap_q_q, omega_q;

  // working registers
  logic signed [DataW-1:0] err_d_q, err_q_q, react_q;
  logic signed [DataW-1:0] integ_d_q, integ_q_q;
  logic signed [DataW:0]   ff_d_q, ff_q_q;
  logic signed [SumW-1:0]  sum_d_q, sum_q_q;
  logic signed [DataW-1:0] res_d_q;
  logic signed [ProdW-1:0] prod_q;

  logic                    out_valid_q;
  logic [2*DataW-1:0]      out_data_q;

  logic take_in;
  logic out_free;
  logic done_go;

  assign take_in  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign done_go  = (state_q == ST_DONE) && out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // error path: reference clamp, subtract, saturate (both axes at once)
  // --------------------------------------------------------------------------
  function automatic logic signed [DataW-1:0] axis_err(
    input logic signed [DataW-1:0] r,
    input logic signed [DataW-1:0] m,
    input logic [LimW-1:0]         lim
  );
    logic signed [DataW:0]   lim_p, lim_n, rw, cl;
    logic signed [DataW+1:0] e;
    lim_p = $signed({2'b00, lim});
    lim_n = -lim_p;
    rw    = {r[DataW-1], r};
    if (rw > lim_p) begin
      cl = lim_p;
    end else if (rw < lim_n) begin
      cl = lim_n;
    end else begin
      cl = rw;
    end
    e = {cl[DataW], cl} - {{2{m[DataW-1]}}, m};
    return sat32({{(WideW-DataW-2){e[DataW+1]}}, e});
  endfunction

  // --------------------------------------------------------------------------
  // shared multiplier operand select; product registered every cycle
  // --------------------------------------------------------------------------
  logic signed [MulW-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_ERR: begin
        mul_a = {omega_q[DataW-1], omega_q};
        mul_b = $signed({1'b0, ind_q});
      end
      ST_REACT: begin
        mul_a = {err_d_q[DataW-1], err_d_q};
        mul_b = $signed({1'b0, ki_q});
      end
      ST_INTD: begin
        mul_a = {react_q[DataW-1], react_q};
        mul_b = {meas_q_q[DataW-1], meas_q_q};
      end
      ST_CRSD: begin
        mul_a = {react_q[DataW-1], react_q};
        mul_b = {meas_d_q[DataW-1], meas_d_q};
      end
      ST_CRSQ: begin
        mul_a = {err_q_q[DataW-1], err_q_q};
        mul_b = $signed({1'b0, ki_q});
      end
      ST_INTQ: begin
        mul_a = {err_d_q[DataW-1], err_d_q};
        mul_b = $signed({1'b0, kp_q});
      end
      ST_SUMD: begin
        mul_a = {err_q_q[DataW-1], err_q_q};
        mul_b = $signed({1'b0, kp_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product views: gain products drop 24 fraction bits, current products 16
  logic signed [SumW-1:0]  prod_g;
  logic signed [WideW-1:0] prod_c;
  assign prod_g = prod_q[ProdW-1:24];
  assign prod_c = prod_q[63:16];

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (take_in) state_d = ST_ERR;
      ST_ERR:   state_d = ST_REACT;
      ST_REACT: state_d = ST_INTD;
      ST_INTD:  state_d = ST_CRSD;
      ST_CRSD:  state_d = ST_CRSQ;
      ST_CRSQ:  state_d = ST_INTQ;
      ST_INTQ:  state_d = ST_SUMD;
      ST_SUMD:  state_d = ST_SUMQ;
      ST_SUMQ:  state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic signed [SumW-1:0]   integ_sum;
  logic signed [DataW-1:0]  integ_sel;
  logic signed [DataW-1:0]  cross_v;
  logic signed [SumW:0]     fin_d, fin_q;

  assign integ_sel = (state_q == ST_INTD) ? integ_d_q : integ_q_q;
  assign integ_sum = prod_g + {{(SumW-DataW){integ_sel[DataW-1]}}, integ_sel};
  assign cross_v   = sat32(prod_c);
  assign fin_d     = {sum_d_q[SumW-1], sum_d_q}
                   + {{(SumW-DataW){ff_d_q[DataW]}}, ff_d_q};
  assign fin_q     = {sum_q_q[SumW-1], sum_q_q}
                   + {{(SumW-DataW){ff_q_q[DataW]}}, ff_q_q};

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      ind_q       <= '0;
      lim_q       <= '0;
      integ_d_q   <= '0;
      integ_q_q   <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROP_GAIN:  kp_q  <= cfg_data_i;
          CFG_INTEG_GAIN: ki_q  <= cfg_data_i;
          CFG_FILTER_IND: ind_q <= cfg_data_i;
          CFG_CURR_LIMIT: lim_q <= cfg_data_i[LimW-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_INTD) begin
        integ_d_q <= sat32({{(WideW-SumW){integ_sum[SumW-1]}}, integ_sum});
      end
      if (state_q == ST_INTQ) begin
        integ_q_q <= sat32({{(WideW-SumW){integ_sum[SumW-1]}}, integ_sum});
      end

      // output register
      if (done_go) begin
        out_valid_q <= 1'b1;
        // disabled tick: result already used the updated integrators
        if (!en_q) begin
          integ_d_q <= '0;
          integ_q_q <= '0;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (take_in) begin
      en_q     <= s_axis_tuser[0];
      ref_d_q  <= s_axis_tdata[0*DataW +: DataW];
      ref_q_q  <= s_axis_tdata[1*DataW +: DataW];
      meas_d_q <= s_axis_tdata[2*DataW +: DataW];
      meas_q_q <= s_axis_tdata[3*DataW +: DataW];
      cap_d_q  <= s_axis_tdata[4*DataW +: DataW];
      cap_q_q  <= s_axis_tdata[5*DataW +: DataW];
      omega_q  <= s_axis_tdata[6*DataW +: DataW];
    end

    if (state_q == ST_ERR) begin
      err_d_q <= axis_err(ref_d_q, meas_d_q, lim_q);
      err_q_q <= axis_err(ref_q_q, meas_q_q, lim_q);
    end

    if (state_q == ST_REACT) begin
      react_q <= sat32({{(WideW-SumW){prod_g[SumW-1]}}, prod_g});
    end

    // feedforward: cap voltage minus / plus the cross term
    if (state_q == ST_CRSD) begin
      ff_d_q <= {cap_d_q[DataW-1], cap_d_q} - {cross_v[DataW-1], cross_v};
    end
    if (state_q == ST_CRSQ) begin
      ff_q_q <= {cap_q_q[DataW-1], cap_q_q} + {cross_v[DataW-1], cross_v};
    end

    if (state_q == ST_SUMD) begin
      sum_d_q <= prod_g + {{(SumW-DataW){integ_d_q[DataW-1]}}, integ_d_q};
    end
    if (state_q == ST_SUMQ) begin
      sum_q_q <= prod_g + {{(SumW-DataW){integ_q_q[DataW-1]}}, integ_q_q};
      res_d_q <= sat32({{(WideW-SumW-1){fin_d[SumW]}}, fin_d});
    end

    if (done_go) begin
      out_data_q <= {sat32({{(WideW-SumW-1){fin_q[SumW]}}, fin_q}), res_d_q};
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // no request is taken while the sequencer works on one
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !take_in)
    else $error("request accepted while busy");

  // a new result only appears from the final step
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_DONE))
    else $error("result valid without finishing a request");

  // a disabled tick leaves both integrators cleared
  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_go && !en_q) |=> (integ_d_q == '0) && (integ_q_q == '0))
    else $error("integrators not cleared after disabled tick");

  // a finished result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dq current pi loop: every accepted request is
// run through a local fixed-point copy of the controller and the drive
// commands that come back are compared in order
// ----------------------------------------------------------------------------

module tb
  import dqpi_pkg::*;
();

  localparam int LATENCY    = 9;     // request to result wait, used by settle
  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer at all
  localparam int SEGMENTS   = 8;
  localparam int SEG_TICKS  = 104;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE   = 32'sh0001_0000;  // 1.0 in Q16.16

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // one control tick as seen on the input stream
  typedef struct {
    bit                 enable;
    logic signed [31:0] ref_d;
    logic signed [31:0] ref_q;
    logic signed [31:0] meas_d;
    logic signed [31:0] meas_q;
    logic signed [31:0] cap_d;
    logic signed [31:0] cap_q;
    logic signed [31:0] omega;
  } tick_t;

  typedef struct {
    logic signed [31:0] d;
    logic signed [31:0] q;
  } drive_t;

  // directed stimulus row: either a register write or a tick
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    tick_t       tick;
    bit          has_fixed;
    drive_t      fixed;
  } plan_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [GainW-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata: ref_d, ref_q, meas_d, meas_q, cap_volt_d, cap_volt_q, angular_freq
  logic [7*DataW-1:0]   s_axis_tdata;
  // tuser: enable
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tdata: drive_d, drive_q
  logic [2*DataW-1:0]   m_axis_tdata;

  dq_current_pi_loop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // local copy of the controller registers and integrators
  logic [31:0]        kp_r = '0;
  logic [31:0]        ki_r = '0;
  logic [31:0]        lind_r = '0;
  logic [30:0]        ilim_r = '0;
  logic signed [31:0] acc_d = '0;
  logic signed [31:0] acc_q = '0;

  drive_t drive_exp_q[$];    // drive commands still owed by the block
  plan_t  plan[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  bit     fixed_valid = 1'b0;  // current tick carries a typed-in result
  drive_t fixed_drive;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clip32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // one axis of the pi loop: returns kp*err + updated integrator
  function automatic longint pi_step(input longint r, input longint m,
                                     input logic signed [31:0] acc,
                                     output logic signed [31:0] acc_next);
    longint lim, e, gp, gi, p, inc;
    lim = {33'h0, ilim_r};
    gp  = {32'h0, kp_r};
    gi  = {32'h0, ki_r};
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    e   = clip32(r - m);
    p   = (e * gp) >>> 24;
    inc = (e * gi) >>> 24;
    acc_next = 32'(clip32(longint'(acc) + inc));
    return p + longint'(acc_next);
  endfunction

  // drive commands for one tick; advances the integrators
  function automatic drive_t predict_drive(tick_t t);
    longint lind, react, xd, xq, pd, pq;
    logic signed [31:0] nd, nq;
    drive_t r;
    lind  = {32'h0, lind_r};
    react = clip32((longint'(t.omega) * lind) >>> 24);
    xd    = clip32((react * longint'(t.meas_q)) >>> 16);
    xq    = clip32((react * longint'(t.meas_d)) >>> 16);
    pd    = pi_step(longint'(t.ref_d), longint'(t.meas_d), acc_d, nd);
    pq    = pi_step(longint'(t.ref_q), longint'(t.meas_q), acc_q, nq);
    acc_d = nd;
    acc_q = nq;
    r.d   = 32'(clip32(pd + longint'(t.cap_d) - xd));
    r.q   = 32'(clip32(pq + longint'(t.cap_q) + xq));
    // disabled tick still uses the updated integrators, then clears them
    if (!t.enable) begin
      acc_d = '0;
      acc_q = '0;
    end
    return r;
  endfunction

  function automatic tick_t mk_tick(bit en, logic signed [31:0] rd, logic signed [31:0] rq,
                                    logic signed [31:0] md, logic signed [31:0] mq,
                                    logic signed [31:0] cd, logic signed [31:0] cq,
                                    logic signed [31:0] w);
    tick_t t;
    t.enable = en;
    t.ref_d  = rd;
    t.ref_q  = rq;
    t.meas_d = md;
    t.meas_q = mq;
    t.cap_d  = cd;
    t.cap_q  = cq;
    t.omega  = w;
    return t;
  endfunction

  // mostly modest magnitudes so saturation is reached only some of the time
  function automatic logic signed [31:0] rand_q16();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2, 3: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    return mk_tick($urandom_range(9) != 0, rand_q16(), rand_q16(), rand_q16(),
                   rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  task automatic add_tick(tick_t t, bit has_fixed = 1'b0,
                          logic signed [31:0] fd = '0, logic signed [31:0] fq = '0);
    plan_t p;
    p.is_cfg    = 1'b0;
    p.idx       = CFG_PROP_GAIN;
    p.val       = '0;
    p.tick      = t;
    p.has_fixed = has_fixed;
    p.fixed.d   = fd;
    p.fixed.q   = fq;
    plan.push_back(p);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
    plan_t p;
    p.is_cfg    = 1'b1;
    p.idx       = idx;
    p.val       = val;
    p.tick      = mk_tick(1'b0, '0, '0, '0, '0, '0, '0, '0);
    p.has_fixed = 1'b0;
    p.fixed.d   = '0;
    p.fixed.q   = '0;
    plan.push_back(p);
  endtask

  // entered and left at a falling edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // entered and left at a falling edge; valid stays up for back-to-back requests
  task automatic send_tick(tick_t t, bit has_fixed, drive_t fx);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.omega, t.cap_q, t.cap_d, t.meas_q, t.meas_d, t.ref_q, t.ref_d};
    s_axis_tuser  <= t.enable;
    fixed_valid   = has_fixed;
    fixed_drive   = fx;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every owed result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    fixed_valid = 1'b0;
    while (drive_exp_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 1) @(negedge clk_i);
  endtask

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // sample both streams and the config port at the rising edge
  always @(posedge clk_i) begin : monitor
    tick_t  t;
    drive_t want;
    drive_t got;
    drive_t calc;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.d = m_axis_tdata[31:0];
        got.q = m_axis_tdata[63:32];
        if (drive_exp_q.size() == 0) begin
          $error("drive result with no request pending: d=%0d q=%0d", got.d, got.q);
          mismatches++;
        end else begin
          want = drive_exp_q.pop_front();
          if (got.d !== want.d) begin
            $error("drive_d: expected %0d, got %0d", want.d, got.d);
            mismatches++;
          end
          if (got.q !== want.q) begin
            $error("drive_q: expected %0d, got %0d", want.q, got.q);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        t.ref_d  = s_axis_tdata[31:0];
        t.ref_q  = s_axis_tdata[63:32];
        t.meas_d = s_axis_tdata[95:64];
        t.meas_q = s_axis_tdata[127:96];
        t.cap_d  = s_axis_tdata[159:128];
        t.cap_q  = s_axis_tdata[191:160];
        t.omega  = s_axis_tdata[223:192];
        t.enable = s_axis_tuser[0];
        calc = predict_drive(t);
        // typed-in rows take the hand-written value; integrators still advance
        drive_exp_q.push_back(fixed_valid ? fixed_drive : calc);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROP_GAIN:  kp_r   = cfg_data_i;
          CFG_INTEG_GAIN: ki_r   = cfg_data_i;
          CFG_FILTER_IND: lind_r = cfg_data_i;
          CFG_CURR_LIMIT: ilim_r = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("dq_current_pi_loop: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seg;
    drive_t none;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PROP_GAIN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    none.d        = '0;
    none.q        = '0;

    // all registers zero after reset: the command is just the capacitor voltage,
    // a zero limit forcing both references to zero
    add_tick(mk_tick(1, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_tick(mk_tick(1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX), 1, Q_MAX, Q_MIN);
    add_tick(mk_tick(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 1, Q_MIN, Q_MAX);
    add_tick(mk_tick(1, 5 * ONE, -3 * ONE, ONE, 2 * ONE, 32'sh1234_5678, -32'sh1000,
                     377 * ONE), 1, 32'sh1234_5678, -32'sh1000);
    // unit proportional gain, widest limit: command equals the error
    add_cfg(CFG_PROP_GAIN, 32'h0100_0000);
    add_cfg(CFG_CURR_LIMIT, 32'h7FFF_FFFF);
    add_tick(mk_tick(1, 5 * ONE, -3 * ONE, 2 * ONE, -ONE, 0, 0, 0), 1, 3 * ONE, -2 * ONE);
    add_tick(mk_tick(1, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 0, 0, 0), 1, Q_MAX, Q_MIN);
    // zero limit again, now with gain: error is minus the measurement
    add_cfg(CFG_CURR_LIMIT, 32'h0);
    add_tick(mk_tick(1, 7 * ONE, -7 * ONE, 3 * ONE, -3 * ONE, ONE, ONE, 0), 1,
             -2 * ONE, 4 * ONE);
    add_cfg(CFG_CURR_LIMIT, 32'h0002_0000);
    add_tick(mk_tick(1, 10 * ONE, -10 * ONE, 0, 0, 0, 0, 0), 1, 2 * ONE, -2 * ONE);
    // realistic loop: integrators build up, then a disabled tick clears them
    add_cfg(CFG_INTEG_GAIN, 32'h0080_0000);
    add_cfg(CFG_FILTER_IND, 32'h0002_8F5C);
    add_cfg(CFG_CURR_LIMIT, 32'h0064_0000);
    add_tick(mk_tick(1, 20 * ONE, -5 * ONE, 18 * ONE, -4 * ONE, 311 * ONE, 0, 377 * ONE));
    add_tick(mk_tick(1, 150 * ONE, -150 * ONE, 19 * ONE, -6 * ONE, 311 * ONE, 2 * ONE,
                     377 * ONE));
    add_tick(mk_tick(1, -30 * ONE, 30 * ONE, -25 * ONE, 27 * ONE, -100 * ONE, 50 * ONE,
                     -377 * ONE));
    add_tick(mk_tick(0, 10 * ONE, 10 * ONE, ONE, -ONE, 0, 0, 377 * ONE));
    add_tick(mk_tick(1, 10 * ONE, 10 * ONE, ONE, -ONE, 0, 0, 377 * ONE));
    // every register at its top value: products and integrators saturate
    add_cfg(CFG_PROP_GAIN, 32'hFFFF_FFFF);
    add_cfg(CFG_INTEG_GAIN, 32'hFFFF_FFFF);
    add_cfg(CFG_FILTER_IND, 32'hFFFF_FFFF);
    add_cfg(CFG_CURR_LIMIT, 32'hFFFF_FFFF);
    add_tick(mk_tick(1, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
    add_tick(mk_tick(1, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    add_tick(mk_tick(1, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 0, 0, ONE));
    add_tick(mk_tick(0, 0, 0, ONE, -ONE, 0, 0, -ONE));
    add_tick(mk_tick(1, ONE, -ONE, 0, 0, 0, 0, 0));
    // zero gains: decoupling term plus capacitor voltage and held integrators
    add_cfg(CFG_PROP_GAIN, 32'h0);
    add_cfg(CFG_INTEG_GAIN, 32'h0);
    add_tick(mk_tick(1, 0, 0, 40 * ONE, -40 * ONE, 0, 0, -377 * ONE));
    add_tick(mk_tick(1, 0, 0, Q_MIN, Q_MAX, ONE, -ONE, Q_MAX));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].tick, plan[i].has_fixed, plan[i].fixed);
      end
    end

    // random segments, each with fresh registers and one of four idling patterns;
    // the sender waits for every owed result before each reconfiguration
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      if (seg == 0) begin
        write_reg(CFG_PROP_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_INTEG_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_FILTER_IND, 32'hFFFF_FFFF);
        write_reg(CFG_CURR_LIMIT, 32'h7FFF_FFFF);
      end else if (seg == 1) begin
        write_reg(CFG_PROP_GAIN, 32'h0);
        write_reg(CFG_INTEG_GAIN, 32'h0);
        write_reg(CFG_FILTER_IND, 32'h0);
        write_reg(CFG_CURR_LIMIT, 32'h0);
      end else begin
        write_reg(CFG_PROP_GAIN, rand_gain());
        write_reg(CFG_INTEG_GAIN, rand_gain());
        write_reg(CFG_FILTER_IND, rand_gain());
        write_reg(CFG_CURR_LIMIT, rand_limit());
      end
      repeat (SEG_TICKS) send_tick(rand_tick(), 1'b0, none);
    end

    settle();
    if (mismatches == 0) begin
      $display("dq_current_pi_loop: match");
    end else begin
      $display("dq_current_pi_loop: mismatch");
    end
    $finish;
  end

endmodule
